/* src/frfa_pkg.sv */
package frfa_pkg;

	// table geometry
	localparam int MAX_RANGES = 256;
	localparam int IDX_W      = $clog2(MAX_RANGES);
	localparam int CNT_W      = IDX_W + 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RANGES);

	// page geometry
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int PFN_W      = 64 - PAGE_SHIFT;
	localparam int PAGES_W    = 53;
	localparam logic [63:0] LOW_BOUND = 64'h0000_0000_0010_0000;

	// opcodes
	localparam logic [2:0] OP_BEGIN   = 3'd0;
	localparam logic [2:0] OP_ADD     = 3'd1;
	localparam logic [2:0] OP_RESERVE = 3'd2;
	localparam logic [2:0] OP_COMMIT  = 3'd3;
	localparam logic [2:0] OP_ALLOC   = 3'd4;
	localparam logic [2:0] OP_FREE    = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_ARG  = 3'd1;
	localparam logic [2:0] ST_NO_MEM   = 3'd2;
	localparam logic [2:0] ST_CAPACITY = 3'd3;
	localparam logic [2:0] ST_INV_FREE = 3'd4;
	localparam logic [2:0] ST_DBL_FREE = 3'd5;
	localparam logic [2:0] ST_NO_FRAME = 3'd6;

	typedef struct packed {
		logic [63:0] s;
		logic [63:0] e;
	} range_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] address;
		logic [63:0] length;
		logic [31:0] frame_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [63:0]        frame_address;
		logic [PAGES_W-1:0] total_count;
		logic [PAGES_W-1:0] free_count;
		logic [CNT_W-1:0]   range_count;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE_GRP,
		S_SETUP_GRP,
		S_SCAN_GRP,
		S_DONE_GRP
	} unused_grp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP1,
		S_SETUP2,
		S_DISPATCH,
		S_MRD,
		S_MPR,
		S_RD,
		S_PR,
		S_SPLIT2,
		S_FLUSH,
		S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		PK_NONE,
		PK_INS,
		PK_CUT,
		PK_ALLOC,
		PK_COPY
	} pass_t;

	typedef struct packed {
		logic accept;
		logic setup1;
		logic setup2;
		logic mrd;
		logic mpr;
		logic prd;
		logic ppr;
		logic split2;
		logic flush;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		pass_t pk;
		logic  is_free;
		logic  mscan_end;
		logic  rd_end;
		logic  pr_stay;
		logic  pr_split;
		logic  flush_stay;
		logic  out_free;
	} dp_stat_t;

endpackage

/* src/frfa_ram.sv */
module frfa_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// one registered read port, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/frfa_ctrl.sv */
module frfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  frfa_pkg::dp_stat_t stat,
	output frfa_pkg::ctl_cmd_t cmd
);

	frfa_pkg::state_t state_q, state_n;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frfa_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			frfa_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = frfa_pkg::S_SETUP1;
				end
			end
			frfa_pkg::S_SETUP1: begin
				cmd.setup1 = 1'b1;
				state_n    = frfa_pkg::S_SETUP2;
			end
			frfa_pkg::S_SETUP2: begin
				cmd.setup2 = 1'b1;
				state_n    = frfa_pkg::S_DISPATCH;
			end
			frfa_pkg::S_DISPATCH: begin
				if (stat.pk == frfa_pkg::PK_NONE) begin
					state_n = frfa_pkg::S_FINISH;
				end else if (stat.is_free) begin
					state_n = frfa_pkg::S_MRD;
				end else begin
					state_n = frfa_pkg::S_RD;
				end
			end
			frfa_pkg::S_MRD: begin
				if (stat.mscan_end) begin
					state_n = frfa_pkg::S_RD;
				end else begin
					cmd.mrd = 1'b1;
					state_n = frfa_pkg::S_MPR;
				end
			end
			frfa_pkg::S_MPR: begin
				cmd.mpr = 1'b1;
				state_n = frfa_pkg::S_MRD;
			end
			frfa_pkg::S_RD: begin
				if (stat.rd_end) begin
					state_n = frfa_pkg::S_FLUSH;
				end else begin
					cmd.prd = 1'b1;
					state_n = frfa_pkg::S_PR;
				end
			end
			frfa_pkg::S_PR: begin
				cmd.ppr = 1'b1;
				if (stat.pr_stay) begin
					state_n = frfa_pkg::S_PR;
				end else if (stat.pr_split) begin
					state_n = frfa_pkg::S_SPLIT2;
				end else begin
					state_n = frfa_pkg::S_RD;
				end
			end
			frfa_pkg::S_SPLIT2: begin
				cmd.split2 = 1'b1;
				state_n    = frfa_pkg::S_RD;
			end
			frfa_pkg::S_FLUSH: begin
				cmd.flush = 1'b1;
				if (!stat.flush_stay) begin
					state_n = frfa_pkg::S_FINISH;
				end
			end
			frfa_pkg::S_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_n    = frfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = frfa_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != frfa_pkg::S_IDLE);

endmodule

/* src/frfa_datapath.sv */
module frfa_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  frfa_pkg::ctl_cmd_t  cmd,
	output frfa_pkg::dp_stat_t  stat,
	input  frfa_pkg::in_item_t  in_item,
	input  logic                cfg_wr,
	input  logic [63:0]         cfg_data,
	input  logic                out_stall,
	output logic                out_valid,
	output frfa_pkg::out_item_t out_item
);

	localparam int PS  = frfa_pkg::PAGE_SHIFT;
	localparam int CW  = frfa_pkg::CNT_W;
	localparam int IW  = frfa_pkg::IDX_W;
	localparam int PW  = frfa_pkg::PAGES_W;
	localparam int RW  = $bits(frfa_pkg::range_t);

	// control state
	logic [63:0]      limit_q;
	logic [CW-1:0]    free_cnt_q, man_cnt_q;
	logic [PW-1:0]    total_q, freep_q;
	logic             ready_q, sel_q, out_valid_q;
	frfa_pkg::pass_t  pk_q;
	logic [CW-1:0]    rd_idx_q, wr_idx_q, m_idx_q, run_cnt_q;
	logic             acc_v_q, n_done_q, hit_q, stop_q, mstop_q;

	// payload registers
	logic [2:0]          op_q, status_q;
	logic [63:0]         addr_q, len_q, bytes_q, ns_q, ne_q, cur_q, first_free_q, frame_q;
	logic [31:0]         cnt_q;
	logic                wrap_q;
	frfa_pkg::range_t    acc_q;
	logic [PW-1:0]       sum_q;
	frfa_pkg::out_item_t out_q;

	// memory ports
	frfa_pkg::range_t b0_rdata, b1_rdata, m_rdata, rdat, wr_data;
	logic             wr_en, man_we;

	frfa_ram #(.DEPTH(frfa_pkg::MAX_RANGES), .WIDTH(RW)) u_bank0 (
		.clk(clk), .we(wr_en && sel_q), .waddr(wr_idx_q[IW-1:0]), .wdata(wr_data),
		.re(cmd.prd && !sel_q), .raddr(rd_idx_q[IW-1:0]), .rdata(b0_rdata)
	);

	frfa_ram #(.DEPTH(frfa_pkg::MAX_RANGES), .WIDTH(RW)) u_bank1 (
		.clk(clk), .we(wr_en && !sel_q), .waddr(wr_idx_q[IW-1:0]), .wdata(wr_data),
		.re(cmd.prd && sel_q), .raddr(rd_idx_q[IW-1:0]), .rdata(b1_rdata)
	);

	frfa_ram #(.DEPTH(frfa_pkg::MAX_RANGES), .WIDTH(RW)) u_managed (
		.clk(clk), .we(man_we), .waddr(rd_idx_q[IW-1:0]), .wdata(rdat),
		.re(cmd.mrd), .raddr(m_idx_q[IW-1:0]), .rdata(m_rdata)
	);

	assign rdat   = sel_q ? b1_rdata : b0_rdata;
	assign man_we = cmd.ppr && (pk_q == frfa_pkg::PK_COPY);

	// first setup cycle: region ends and wrap
	logic [63:0] addend, s1, e1;
	logic [64:0] sum65;

	always_comb begin
		addend = (op_q == frfa_pkg::OP_FREE) ? bytes_q : len_q;
		sum65  = {1'b0, addr_q} + {1'b0, addend};
		s1     = addr_q;
		e1     = sum65[63:0];
		if (op_q == frfa_pkg::OP_ADD) begin
			s1 = (addr_q < frfa_pkg::LOW_BOUND) ? frfa_pkg::LOW_BOUND : addr_q;
			e1 = (sum65[63:0] > limit_q) ? limit_q : sum65[63:0];
		end else if (op_q == frfa_pkg::OP_RESERVE) begin
			s1 = {addr_q[63:PS], {PS{1'b0}}};
		end
	end

	// second setup cycle: page alignment and argument checks
	logic [63:0]     ns_al, ne_dn, ne_up, s2_ns, s2_ne;
	logic            ns_ovf, ne_top;
	logic [2:0]      st_n;
	frfa_pkg::pass_t pk_n;

	always_comb begin
		ns_ovf = &ns_q[63:PS];
		ne_top = &ne_q[63:PS];
		ns_al  = (ns_q[PS-1:0] != '0) ? {ns_q[63:PS] + 1'b1, {PS{1'b0}}} : ns_q;
		ne_dn  = {ne_q[63:PS], {PS{1'b0}}};
		ne_up  = ((ne_q[PS-1:0] != '0) && !ne_top) ?
			{ne_q[63:PS] + 1'b1, {PS{1'b0}}} : ne_dn;
		s2_ns  = ns_q;
		s2_ne  = ne_q;
		st_n   = frfa_pkg::ST_OK;
		pk_n   = frfa_pkg::PK_NONE;
		case (op_q)
			frfa_pkg::OP_BEGIN: begin
				st_n = frfa_pkg::ST_OK;
			end
			frfa_pkg::OP_ADD: begin
				s2_ns = ns_al;
				s2_ne = ne_dn;
				if (ready_q || limit_q <= frfa_pkg::LOW_BOUND) begin
					st_n = frfa_pkg::ST_BAD_ARG;
				end else if (len_q == '0) begin
					st_n = frfa_pkg::ST_OK;
				end else if (wrap_q) begin
					st_n = frfa_pkg::ST_BAD_ARG;
				end else if ((ns_q[PS-1:0] != '0) && ns_ovf) begin
					st_n = frfa_pkg::ST_OK;
				end else if (ns_al >= ne_dn) begin
					st_n = frfa_pkg::ST_OK;
				end else if (free_cnt_q == frfa_pkg::MAX_CNT) begin
					st_n = frfa_pkg::ST_CAPACITY;
				end else begin
					pk_n = frfa_pkg::PK_INS;
				end
			end
			frfa_pkg::OP_RESERVE: begin
				s2_ne = ne_up;
				if (ready_q) begin
					st_n = frfa_pkg::ST_BAD_ARG;
				end else if (len_q == '0) begin
					st_n = frfa_pkg::ST_OK;
				end else if (wrap_q) begin
					st_n = frfa_pkg::ST_BAD_ARG;
				end else if (ns_q >= ne_up) begin
					st_n = frfa_pkg::ST_OK;
				end else begin
					pk_n = frfa_pkg::PK_CUT;
				end
			end
			frfa_pkg::OP_COMMIT: begin
				if (ready_q) begin
					st_n = frfa_pkg::ST_BAD_ARG;
				end else if (free_cnt_q == '0) begin
					st_n = frfa_pkg::ST_NO_MEM;
				end else begin
					pk_n = frfa_pkg::PK_COPY;
				end
			end
			frfa_pkg::OP_ALLOC: begin
				st_n = frfa_pkg::ST_NO_FRAME;
				if (ready_q && cnt_q != '0 && PW'(cnt_q) <= freep_q) begin
					pk_n = frfa_pkg::PK_ALLOC;
				end
			end
			frfa_pkg::OP_FREE: begin
				if (!ready_q || cnt_q == '0 || addr_q[PS-1:0] != '0 || wrap_q) begin
					st_n = frfa_pkg::ST_INV_FREE;
				end else begin
					pk_n = frfa_pkg::PK_INS;
				end
			end
			default: begin
				st_n = frfa_pkg::ST_BAD_ARG;
			end
		endcase
	end

	// insert: merging feed of the new range or a table entry
	logic             feed_n, ins_feed, merge, ov_hit;
	frfa_pkg::range_t feed_x;

	always_comb begin
		feed_n   = !n_done_q && (rdat.s >= ns_q);
		ins_feed = (pk_q == frfa_pkg::PK_INS) &&
			(cmd.ppr || (cmd.flush && !n_done_q));
		feed_x   = (cmd.flush || feed_n) ? '{s: ns_q, e: ne_q} : rdat;
		merge    = acc_v_q && (acc_q.e >= feed_x.s);
		ov_hit   = !hit_q && (rdat.e > ns_q) && (rdat.s < ne_q);
	end

	// cut: where the entry sits against the reserved span
	logic c_none, c_lo, c_hi, run_full, c_split;

	always_comb begin
		c_none   = (ne_q <= rdat.s) || (ns_q >= rdat.e);
		c_lo     = ns_q <= rdat.s;
		c_hi     = ne_q >= rdat.e;
		run_full = run_cnt_q >= frfa_pkg::MAX_CNT;
		c_split  = !stop_q && !c_none && !c_lo && !c_hi;
	end

	// allocate: first range large enough
	logic [63:0] a_len, a_ns;
	logic        a_fit;

	always_comb begin
		a_len = rdat.e - rdat.s;
		a_ns  = rdat.s + bytes_q;
		a_fit = !hit_q && (a_len >= bytes_q);
	end

	// bank write port
	always_comb begin
		wr_en   = 1'b0;
		wr_data = acc_q;
		if (ins_feed && !merge && acc_v_q) begin
			wr_en = 1'b1;
		end
		if (cmd.flush && pk_q == frfa_pkg::PK_INS && n_done_q && acc_v_q) begin
			wr_en = 1'b1;
		end
		if (cmd.split2) begin
			wr_en = 1'b1;
		end
		if (cmd.ppr && pk_q == frfa_pkg::PK_CUT) begin
			if (stop_q || c_none) begin
				wr_en   = 1'b1;
				wr_data = rdat;
			end else if (c_lo && c_hi) begin
				wr_en = 1'b0;
			end else if (c_lo) begin
				wr_en   = 1'b1;
				wr_data = '{s: ne_q, e: rdat.e};
			end else if (c_hi) begin
				wr_en   = 1'b1;
				wr_data = '{s: rdat.s, e: ns_q};
			end else if (run_full) begin
				wr_en   = 1'b1;
				wr_data = rdat;
			end else begin
				wr_en   = 1'b1;
				wr_data = '{s: rdat.s, e: ns_q};
			end
		end
		if (cmd.ppr && pk_q == frfa_pkg::PK_ALLOC) begin
			wr_en   = !a_fit || (a_ns != rdat.e);
			wr_data = a_fit ? '{s: a_ns, e: rdat.e} : rdat;
		end
	end

	// end of operation: verdict and new statistics
	logic [2:0]    fin_st;
	logic [63:0]   fin_frame;
	logic          fin_swap, unman;
	logic [CW-1:0] fin_free_cnt;
	logic [PW-1:0] fin_freep;

	always_comb begin
		fin_st       = status_q;
		fin_frame    = '0;
		fin_swap     = 1'b0;
		fin_free_cnt = free_cnt_q;
		fin_freep    = freep_q;
		unman        = cur_q < ne_q;
		case (pk_q)
			frfa_pkg::PK_INS: begin
				if (op_q == frfa_pkg::OP_FREE) begin
					if (unman && (!hit_q || cur_q <= first_free_q)) begin
						fin_st = frfa_pkg::ST_INV_FREE;
					end else if (hit_q) begin
						fin_st = frfa_pkg::ST_DBL_FREE;
					end else if (free_cnt_q == frfa_pkg::MAX_CNT) begin
						fin_st = frfa_pkg::ST_CAPACITY;
					end else begin
						fin_st       = frfa_pkg::ST_OK;
						fin_swap     = 1'b1;
						fin_free_cnt = wr_idx_q;
						fin_freep    = freep_q + PW'(cnt_q);
					end
				end else begin
					fin_swap     = 1'b1;
					fin_free_cnt = wr_idx_q;
				end
			end
			frfa_pkg::PK_CUT: begin
				fin_swap     = 1'b1;
				fin_free_cnt = wr_idx_q;
			end
			frfa_pkg::PK_ALLOC: begin
				if (hit_q) begin
					fin_st       = frfa_pkg::ST_OK;
					fin_frame    = frame_q;
					fin_swap     = 1'b1;
					fin_free_cnt = wr_idx_q;
					fin_freep    = freep_q - PW'(cnt_q);
				end else begin
					fin_st = frfa_pkg::ST_NO_FRAME;
				end
			end
			frfa_pkg::PK_COPY: begin
				fin_st    = frfa_pkg::ST_OK;
				fin_freep = sum_q;
			end
			default: begin
				fin_st = status_q;
			end
		endcase
	end

	// allocator state and table counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= '0;
			free_cnt_q  <= '0;
			man_cnt_q   <= '0;
			total_q     <= '0;
			freep_q     <= '0;
			ready_q     <= 1'b0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				limit_q <= cfg_data;
			end
			if (cmd.setup2 && op_q == frfa_pkg::OP_BEGIN) begin
				free_cnt_q <= '0;
				man_cnt_q  <= '0;
				total_q    <= '0;
				freep_q    <= '0;
				ready_q    <= 1'b0;
			end
			if (cmd.finish) begin
				free_cnt_q <= fin_free_cnt;
				freep_q    <= fin_freep;
				if (fin_swap) begin
					sel_q <= !sel_q;
				end
				if (pk_q == frfa_pkg::PK_COPY) begin
					man_cnt_q <= free_cnt_q;
					total_q   <= sum_q;
					ready_q   <= 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pass sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_q      <= frfa_pkg::PK_NONE;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			m_idx_q   <= '0;
			run_cnt_q <= '0;
			acc_v_q   <= 1'b0;
			n_done_q  <= 1'b0;
			hit_q     <= 1'b0;
			stop_q    <= 1'b0;
			mstop_q   <= 1'b0;
		end else begin
			if (cmd.setup2) begin
				pk_q      <= pk_n;
				rd_idx_q  <= '0;
				wr_idx_q  <= '0;
				m_idx_q   <= '0;
				run_cnt_q <= free_cnt_q;
				acc_v_q   <= 1'b0;
				n_done_q  <= 1'b0;
				hit_q     <= 1'b0;
				stop_q    <= 1'b0;
				mstop_q   <= 1'b0;
			end
			if (wr_en) begin
				wr_idx_q <= wr_idx_q + 1'b1;
			end
			if (ins_feed && !merge) begin
				acc_v_q <= 1'b1;
			end
			if (ins_feed && (cmd.flush || feed_n)) begin
				n_done_q <= 1'b1;
			end
			if (cmd.mpr) begin
				if (m_rdata.e <= cur_q) begin
					m_idx_q <= m_idx_q + 1'b1;
				end else if (m_rdata.s > cur_q) begin
					mstop_q <= 1'b1;
				end else begin
					m_idx_q <= m_idx_q + 1'b1;
				end
			end
			if (cmd.ppr) begin
				case (pk_q)
					frfa_pkg::PK_INS: begin
						if (!feed_n) begin
							rd_idx_q <= rd_idx_q + 1'b1;
							if (ov_hit) begin
								hit_q <= 1'b1;
							end
						end
					end
					frfa_pkg::PK_CUT: begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (!stop_q && !c_none && c_lo && c_hi) begin
							run_cnt_q <= run_cnt_q - 1'b1;
						end else if (c_split && run_full) begin
							stop_q <= 1'b1;
						end else if (c_split) begin
							run_cnt_q <= run_cnt_q + 1'b1;
						end
					end
					frfa_pkg::PK_ALLOC: begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (a_fit) begin
							hit_q <= 1'b1;
						end
					end
					frfa_pkg::PK_COPY: begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					default: begin
						rd_idx_q <= rd_idx_q;
					end
				endcase
			end
		end
	end

	// operands, accumulator and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_item.opcode;
			addr_q  <= in_item.address;
			len_q   <= in_item.length;
			cnt_q   <= in_item.frame_count;
			bytes_q <= {32'b0, in_item.frame_count} << PS;
		end
		if (cmd.setup1) begin
			ns_q   <= s1;
			ne_q   <= e1;
			wrap_q <= sum65[64];
		end
		if (cmd.setup2) begin
			ns_q     <= s2_ns;
			ne_q     <= s2_ne;
			status_q <= st_n;
			cur_q    <= ns_q;
			sum_q    <= '0;
			frame_q  <= '0;
		end
		if (cmd.mpr && m_rdata.e > cur_q && m_rdata.s <= cur_q) begin
			cur_q <= m_rdata.e;
		end
		if (ins_feed) begin
			if (merge) begin
				if (feed_x.e > acc_q.e) begin
					acc_q.e <= feed_x.e;
				end
			end else begin
				acc_q <= feed_x;
			end
		end
		if (cmd.ppr && pk_q == frfa_pkg::PK_INS && !feed_n && ov_hit) begin
			first_free_q <= (rdat.s > ns_q) ? rdat.s : ns_q;
		end
		if (cmd.ppr && pk_q == frfa_pkg::PK_CUT && c_split) begin
			if (run_full) begin
				status_q <= frfa_pkg::ST_CAPACITY;
			end else begin
				acc_q <= '{s: ne_q, e: rdat.e};
			end
		end
		if (cmd.ppr && pk_q == frfa_pkg::PK_ALLOC && a_fit) begin
			frame_q <= rdat.s;
		end
		if (cmd.ppr && pk_q == frfa_pkg::PK_COPY) begin
			sum_q <= sum_q + PW'((rdat.e - rdat.s) >> PS);
		end
		if (cmd.finish) begin
			out_q.status        <= fin_st;
			out_q.frame_address <= fin_frame;
			out_q.total_count   <= (pk_q == frfa_pkg::PK_COPY) ? sum_q :
				((cmd.finish && op_q == frfa_pkg::OP_BEGIN) ? '0 : total_q);
			out_q.free_count    <= fin_freep;
			out_q.range_count   <= fin_free_cnt;
		end
	end

	// status to the controller
	always_comb begin
		stat.pk         = pk_q;
		stat.is_free    = (op_q == frfa_pkg::OP_FREE);
		stat.mscan_end  = (m_idx_q == man_cnt_q) || (cur_q >= ne_q) || mstop_q;
		stat.rd_end     = (rd_idx_q == free_cnt_q);
		stat.pr_stay    = (pk_q == frfa_pkg::PK_INS) && feed_n;
		stat.pr_split   = (pk_q == frfa_pkg::PK_CUT) && c_split && !run_full;
		stat.flush_stay = (pk_q == frfa_pkg::PK_INS) && !n_done_q;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* src/free_range_frame_allocator.sv */
// Page frame allocator over a sorted, coalesced table of free page ranges (up to 256
// entries, 4 KiB pages). Each accepted item gives exactly one result. An item runs
// the setup states SETUP1, SETUP2 and DISPATCH, then table work that reads one entry
// at a time through the single read port of the table memory, a read state and a
// process state for each entry; free first scans the managed table the same way.
// The free table is double banked: every update rewrites it into the other bank and a
// failed operation keeps the old bank, save a reserve that runs out of table room,
// which still switches to the partly cut table. The result register lets the next item
// be taken while a result still waits. Write physical_memory_limit only while idle.
module free_range_frame_allocator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  frfa_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output frfa_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [63:0]         cfg_data
);

	frfa_pkg::ctl_cmd_t cmd;
	frfa_pkg::dp_stat_t stat;

	// configuration register always takes a write
	assign cfg_ready = 1'b1;

	frfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	frfa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_item   (in_item),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule
